[hw/rtl/trz_pkg.sv]
// shared constants, types and state codes of the triangle rasterizer
// used by the channel interfaces, the divider and the top level
`default_nettype none

package trz_pkg;

    localparam int SCREEN_W    = 128;
    localparam int SCREEN_H    = 128;
    localparam int FIX_ONE     = 1024;
    localparam int TEXEL_WORDS = 4096;

    localparam int FIX_SH = $clog2(FIX_ONE);
    localparam int PIX_N  = SCREEN_W * SCREEN_H;
    localparam int PIX_AW = $clog2(PIX_N);
    localparam int XW     = $clog2(SCREEN_W + 1);
    localparam int YW     = $clog2(SCREEN_H + 1);
    localparam int TEX_AW = $clog2(TEXEL_WORDS);

    localparam int CMD_W = 3;
    localparam int SLT_W = 2;
    localparam int CRD_W = 12;
    localparam int DEP_W = 15;
    localparam int COL_W = 16;
    localparam int UV_W  = 8;
    localparam int SH_W  = 8;
    localparam int TB_W  = 12;
    localparam int TSZ_W = 7;
    localparam int ZST_W = 16;
    localparam int CNT_W = 15;
    localparam int SCR_W = 5;
    localparam int NIB_W = 4;

    localparam int E_W    = 2 * CRD_W + 4;
    localparam int W_W    = FIX_SH + 1;
    localparam int ZI_W   = 2 * FIX_SH + 1;
    localparam int DEN_W  = 3 * FIX_SH + 1;
    localparam int Z_W    = DEP_W + 2;
    localparam int DIV_NW = (E_W + FIX_SH > DEN_W) ? E_W + FIX_SH : DEN_W;
    localparam int DIV_DW = (DEN_W > E_W) ? DEN_W : E_W;
    localparam int DIV_CW = $clog2(DIV_NW + 1);
    localparam int MA_W   = (CRD_W + 2 > FIX_SH + 2) ? CRD_W + 2 : FIX_SH + 2;
    localparam int MB_W   = (CRD_W + 2 > ZI_W + 1) ? CRD_W + 2 : ZI_W + 1;
    localparam int ACC_W  = MA_W + MB_W + 4;

    localparam int SCROLL_ROWS = 32;
    localparam int NIBBLE_MAX  = 15;
    localparam int CNT_MAX     = (1 << CNT_W) - 1;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DRAW  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TEXEL = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

    localparam logic [SH_W-1:0] SH_FLAT    = 8'd1;
    localparam logic [SH_W-1:0] SH_GOURAUD = 8'd2;
    localparam logic [SH_W-1:0] SH_TEXTURE = 8'd100;
    localparam logic [SH_W-1:0] SH_SCROLL  = 8'd101;

    localparam int CFG_IW = 2;
    localparam int CFG_DW = 16;
    localparam logic [CFG_IW-1:0] CFG_SKY    = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_FORCE  = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_SCROLL = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic [SLT_W-1:0]        vertex_slot;
        logic signed [CRD_W-1:0] pos_x;
        logic signed [CRD_W-1:0] pos_y;
        logic [DEP_W-1:0]        depth_in;
        logic [COL_W-1:0]        color_in;
        logic [UV_W-1:0]         tex_u;
        logic [UV_W-1:0]         tex_v;
        logic [SH_W-1:0]         shader_sel;
        logic [TB_W-1:0]         tex_base;
        logic [TSZ_W-1:0]        tex_size;
    } t_cmd;

    typedef struct packed {
        logic [COL_W-1:0]        read_color;
        logic signed [ZST_W-1:0] read_depth;
        logic [CNT_W-1:0]        pixels_drawn;
    } t_res;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quo;
    } t_div_rsp;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_RDWAIT,
        ST_RDCAP,
        ST_ZI,
        ST_AREA,
        ST_BOX,
        ST_EDGE,
        ST_COVER,
        ST_W1,
        ST_W2,
        ST_DEN,
        ST_Z,
        ST_TEST,
        ST_SHADE,
        ST_FWR,
        ST_TADDR,
        ST_TEXRD,
        ST_TEXWR,
        ST_NEXT,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

[hw/rtl/trz_ifs.sv]
// valid/ready channel interfaces for command words and result words
// depends on trz_pkg for the payload types
`default_nettype none

interface trz_cmd_if;
    logic         valid;
    logic         ready;
    trz_pkg::t_cmd data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface trz_res_if;
    logic         valid;
    logic         ready;
    trz_pkg::t_res data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/trz_ram.sv]
// generic single-write, single-read memory with registered read data
// no dependencies
`default_nettype none

module trz_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[hw/rtl/trz_div.sv]
// shared restoring divider, one quotient bit per cycle
// depends on trz_pkg for widths and request/response structs
`default_nettype none

module trz_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire trz_pkg::t_div_req i_req,
    output      trz_pkg::t_div_rsp o_rsp
);
    import trz_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DIV_CW-1:0] r_cnt;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_den;
    logic [DIV_NW-1:0] r_q;

    logic [DIV_DW:0] shifted;
    logic [DIV_DW:0] diff;
    logic            ge;

    assign shifted = {r_rem, r_q[DIV_NW-1]};
    assign diff    = shifted - {1'b0, r_den};
    assign ge      = !diff[DIV_DW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CW'(DIV_NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_den <= i_req.den;
            r_q   <= i_req.num;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DIV_DW-1:0] : shifted[DIV_DW-1:0];
            r_q   <= {r_q[DIV_NW-2:0], ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_q;

endmodule

`default_nettype wire

[hw/rtl/triangle_rasterizer_zbuffer.sv]
// triangle rasterizer with depth store: sequencer, shared multiply-accumulate
// depends on trz_pkg, trz_ifs, trz_ram and trz_div
//
// Command words arrive on i_cmd and every command returns one result word on
// o_res. i_cmd.ready is high only while the sequencer is idle; one command is
// worked on at a time. The result sits in an output register, so the next
// command is taken while a result still waits; a stalled receiver holds back
// only the end of the following command.
// A clear writes one entry of both stores per cycle. A draw first takes the
// reciprocal depths and the area, then walks the box: every pixel gets its
// edge values, and a covered pixel also gets its weights, depth, depth test
// and shading. The single restoring divider (one quotient bit per cycle) does
// the divisions, with the multiply-accumulate unit doing edges, depth and
// shading sums.
// Configuration writes on i_cfg_* take effect at once and belong in idle time.
// Reset clears the vertices, the configuration and the sequencer; frame and depth
// stores hold nothing valid until the first clear, the texel store until written.
`default_nettype none

module triangle_rasterizer_zbuffer (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    trz_cmd_if.sink                          i_cmd,
    trz_res_if.source                        o_res,
    input  wire logic                        i_cfg_we,
    input  wire logic [trz_pkg::CFG_IW-1:0]  i_cfg_idx,
    input  wire logic [trz_pkg::CFG_DW-1:0]  i_cfg_data
);
    import trz_pkg::*;

    t_state r_state, n_state;

    logic [COL_W-1:0] r_sky;
    logic [SH_W-1:0]  r_force;
    logic [SCR_W-1:0] r_scroll;

    logic signed [CRD_W-1:0] r_vx [3];
    logic signed [CRD_W-1:0] r_vy [3];
    logic [DEP_W-1:0]        r_vd [3];
    logic [COL_W-1:0]        r_col [3];
    logic [UV_W-1:0]         r_vu [3];
    logic [UV_W-1:0]         r_vv [3];

    logic [SH_W-1:0]  r_shader;
    logic [TB_W-1:0]  r_base;
    logic [TSZ_W-1:0] r_size;

    logic [ZI_W-1:0]         r_zi [3];
    logic signed [E_W-1:0]   r_area;
    logic signed [E_W-1:0]   r_e [3];
    logic [W_W-1:0]          r_w [3];
    logic [DEN_W-1:0]        r_den;
    logic [Z_W-1:0]          r_z;
    logic signed [ACC_W-1:0] r_acc;
    logic [2:0]              r_stp;
    logic [1:0]              r_ch;
    logic                    r_dact;

    logic [XW-1:0] r_px, r_xs, r_xl;
    logic [YW-1:0] r_py, r_ys, r_yl;
    logic [PIX_AW-1:0] r_clr;
    logic              r_inscr;

    logic [COL_W-1:0]  r_fcol;
    logic [UV_W-1:0]   r_iu, r_iv;
    logic [TEX_AW-1:0] r_taddr;

    logic [COL_W-1:0]  r_rcol;
    logic [ZST_W-1:0]  r_rdep;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_ovalid;
    t_res              r_out;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic                    mac_en, mac_clr, mac_sub;
    logic signed [MA_W-1:0]  mac_a;
    logic signed [MB_W-1:0]  mac_b;
    logic signed [MA_W+MB_W-1:0] mac_p;
    logic signed [ACC_W-1:0] acc_next;

    logic              fr_we, dp_we, tx_we;
    logic [PIX_AW-1:0] pix_addr, st_waddr;
    logic [COL_W-1:0]  fr_wdata, fr_rdata;
    logic [ZST_W-1:0]  dp_wdata, dp_rdata;
    logic [COL_W-1:0]  tx_rdata;
    logic [TEX_AW-1:0] tx_waddr;

    logic accept, any_neg, pass, last_x, last_y;
    logic signed [CRD_W+1:0] mnx, mxx, mny, mxy, xs_c, xl_c, ys_c, yl_c;
    logic box_ok;
    logic [TSZ_W-1:0] lim, uc, vc;
    logic [19:0]      taddr_full;

    function automatic logic [1:0] nxt1(input logic [1:0] k);
        case (k)
            2'd0:    nxt1 = 2'd1;
            2'd1:    nxt1 = 2'd2;
            default: nxt1 = 2'd0;
        endcase
    endfunction

    function automatic logic [NIB_W-1:0] nib_of(input logic [COL_W-1:0] c,
                                               input logic [1:0] ch);
        case (ch)
            2'd0:    nib_of = c[3:0];
            2'd1:    nib_of = c[11:8];
            default: nib_of = c[15:12];
        endcase
    endfunction

    assign accept      = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = (r_state == ST_IDLE);
    assign o_res.valid = r_ovalid;
    assign o_res.data  = r_out;

    // shared multiply-accumulate
    assign mac_p    = mac_a * mac_b;
    assign acc_next = (mac_clr ? ACC_W'(0) : r_acc)
                    + (mac_sub ? -ACC_W'(mac_p) : ACC_W'(mac_p));

    assign pix_addr = PIX_AW'(r_py * SCREEN_W) + PIX_AW'(r_px);
    assign any_neg  = r_e[0][E_W-1] || r_e[1][E_W-1] || r_e[2][E_W-1];
    assign pass     = !(dp_rdata[ZST_W-1] || ({1'b0, dp_rdata} < r_z));
    assign last_x   = ((XW+1)'(r_px) + 1'b1) >= (XW+1)'(r_xl);
    assign last_y   = ((YW+1)'(r_py) + 1'b1) >= (YW+1)'(r_yl);

    // bounding box clipped to the screen
    always_comb begin
        mnx = (CRD_W+2)'(r_vx[0]);
        mxx = (CRD_W+2)'(r_vx[0]);
        mny = (CRD_W+2)'(r_vy[0]);
        mxy = (CRD_W+2)'(r_vy[0]);
        for (int i = 1; i < 3; i++) begin
            if ((CRD_W+2)'(r_vx[i]) < mnx) mnx = (CRD_W+2)'(r_vx[i]);
            if ((CRD_W+2)'(r_vx[i]) > mxx) mxx = (CRD_W+2)'(r_vx[i]);
            if ((CRD_W+2)'(r_vy[i]) < mny) mny = (CRD_W+2)'(r_vy[i]);
            if ((CRD_W+2)'(r_vy[i]) > mxy) mxy = (CRD_W+2)'(r_vy[i]);
        end
        xs_c = (mnx < 0) ? '0 : mnx;
        ys_c = (mny < 0) ? '0 : mny;
        xl_c = (mxx > (CRD_W+2)'(SCREEN_W)) ? (CRD_W+2)'(SCREEN_W) : mxx;
        yl_c = (mxy > (CRD_W+2)'(SCREEN_H)) ? (CRD_W+2)'(SCREEN_H) : mxy;
        box_ok = (r_area > 0) && (xs_c < xl_c) && (ys_c < yl_c);
    end

    // texel address
    always_comb begin
        lim = r_size - 1'b1;
        uc  = ({1'b0, r_iu} > (UV_W+1)'(lim)) ? lim : TSZ_W'(r_iu);
        vc  = ({1'b0, r_iv} > (UV_W+1)'(lim)) ? lim : TSZ_W'(r_iv);
        if (r_shader == SH_SCROLL) begin
            uc = TSZ_W'(SCR_W'(uc[SCR_W-1:0] + r_scroll));
        end
        taddr_full = 20'(r_base) + 20'(uc) * 20'(r_size) + 20'(vc);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (i_cmd.data.cmd)
                        CMD_CLEAR: n_state = ST_CLEAR;
                        CMD_DRAW:  n_state = ST_ZI;
                        CMD_READ:  n_state = ST_RDWAIT;
                        default:   n_state = ST_DONE;
                    endcase
                end
            end
            ST_CLEAR:  if (r_clr == PIX_AW'(PIX_N - 1)) n_state = ST_DONE;
            ST_RDWAIT: n_state = ST_RDCAP;
            ST_RDCAP:  n_state = ST_DONE;
            ST_ZI:     if (div_rsp.done && r_stp == 3'd2) n_state = ST_AREA;
            ST_AREA:   if (r_stp == 3'd1) n_state = ST_BOX;
            ST_BOX:    n_state = box_ok ? ST_EDGE : ST_DONE;
            ST_EDGE:   if (r_stp == 3'd5) n_state = ST_COVER;
            ST_COVER:  n_state = any_neg ? ST_NEXT : ST_W1;
            ST_W1:     if (div_rsp.done) n_state = ST_W2;
            ST_W2:     if (div_rsp.done) n_state = ST_DEN;
            ST_DEN:    if (r_stp == 3'd2) n_state = ST_Z;
            ST_Z:      if (div_rsp.done) n_state = ST_TEST;
            ST_TEST: begin
                if (pass && (r_shader == SH_GOURAUD || r_shader == SH_TEXTURE
                             || r_shader == SH_SCROLL)) begin
                    n_state = ST_SHADE;
                end else begin
                    n_state = ST_NEXT;
                end
            end
            ST_SHADE: begin
                if (r_stp == 3'd2) begin
                    if (r_shader == SH_GOURAUD && r_ch == 2'd2) n_state = ST_FWR;
                    if (r_shader != SH_GOURAUD && r_ch == 2'd1) n_state = ST_TADDR;
                end
            end
            ST_FWR:   n_state = ST_NEXT;
            ST_TADDR: n_state = ST_TEXRD;
            ST_TEXRD: n_state = ST_TEXWR;
            ST_TEXWR: n_state = ST_NEXT;
            ST_NEXT:  n_state = (last_x && last_y) ? ST_DONE : ST_EDGE;
            ST_DONE:  if (!r_ovalid || o_res.ready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // datapath controls
    always_comb begin
        logic [1:0] k, p, q;
        k = r_stp[2:1];
        p = nxt1(k);
        q = nxt1(p);
        mac_en  = 1'b0;
        mac_clr = 1'b0;
        mac_sub = 1'b0;
        mac_a   = '0;
        mac_b   = '0;
        div_req.start = 1'b0;
        div_req.num   = '0;
        div_req.den   = DIV_DW'(1);
        fr_we    = 1'b0;
        dp_we    = 1'b0;
        fr_wdata = r_fcol;
        dp_wdata = ZST_W'(FIX_ONE);
        st_waddr = pix_addr;
        case (r_state)
            ST_CLEAR: begin
                fr_we    = 1'b1;
                dp_we    = 1'b1;
                fr_wdata = r_sky;
                st_waddr = r_clr;
            end
            ST_ZI: begin
                div_req.start = !r_dact;
                div_req.num   = DIV_NW'(1) << (2 * FIX_SH);
                div_req.den   = (r_vd[r_stp[1:0]] == '0) ? DIV_DW'(1)
                                                         : DIV_DW'(r_vd[r_stp[1:0]]);
            end
            ST_AREA: begin
                mac_en  = 1'b1;
                mac_clr = (r_stp == 3'd0);
                mac_sub = (r_stp != 3'd0);
                if (r_stp == 3'd0) begin
                    mac_a = MA_W'(r_vx[2]) - MA_W'(r_vx[0]);
                    mac_b = MB_W'(r_vy[1]) - MB_W'(r_vy[0]);
                end else begin
                    mac_a = MA_W'(r_vy[2]) - MA_W'(r_vy[0]);
                    mac_b = MB_W'(r_vx[1]) - MB_W'(r_vx[0]);
                end
            end
            ST_EDGE: begin
                mac_en  = 1'b1;
                mac_clr = !r_stp[0];
                mac_sub = r_stp[0];
                if (!r_stp[0]) begin
                    mac_a = MA_W'($signed({1'b0, r_px})) - MA_W'(r_vx[p]);
                    mac_b = MB_W'(r_vy[q]) - MB_W'(r_vy[p]);
                end else begin
                    mac_a = MA_W'($signed({1'b0, r_py})) - MA_W'(r_vy[p]);
                    mac_b = MB_W'(r_vx[q]) - MB_W'(r_vx[p]);
                end
            end
            ST_W1: begin
                div_req.start = !r_dact;
                div_req.num   = DIV_NW'(r_e[0][E_W-2:0]) << FIX_SH;
                div_req.den   = DIV_DW'(r_area[E_W-2:0]);
            end
            ST_W2: begin
                div_req.start = !r_dact;
                div_req.num   = DIV_NW'(r_e[1][E_W-2:0]) << FIX_SH;
                div_req.den   = DIV_DW'(r_area[E_W-2:0]);
            end
            ST_DEN: begin
                mac_en  = 1'b1;
                mac_clr = (r_stp == 3'd0);
                mac_a   = MA_W'($signed({1'b0, r_w[r_stp[1:0]]}));
                mac_b   = MB_W'($signed({1'b0, r_zi[r_stp[1:0]]}));
            end
            ST_Z: begin
                div_req.start = !r_dact;
                div_req.num   = DIV_NW'(1) << (3 * FIX_SH);
                div_req.den   = (r_den == '0) ? DIV_DW'(1) : DIV_DW'(r_den);
            end
            ST_TEST: begin
                dp_we    = pass;
                dp_wdata = r_z[ZST_W-1:0];
                fr_we    = pass && (r_shader == SH_FLAT);
                fr_wdata = r_col[0];
            end
            ST_SHADE: begin
                mac_en  = 1'b1;
                mac_clr = (r_stp == 3'd0);
                mac_a   = MA_W'($signed({1'b0, r_w[r_stp[1:0]]}));
                if (r_shader == SH_GOURAUD) begin
                    mac_b = MB_W'($signed({1'b0, nib_of(r_col[r_stp[1:0]], r_ch)}));
                end else if (r_ch == 2'd0) begin
                    mac_b = MB_W'($signed({1'b0, r_vu[r_stp[1:0]]}));
                end else begin
                    mac_b = MB_W'($signed({1'b0, r_vv[r_stp[1:0]]}));
                end
            end
            ST_FWR: begin
                fr_we = 1'b1;
            end
            ST_TEXWR: begin
                fr_we    = 1'b1;
                fr_wdata = tx_rdata;
            end
            default: begin
                mac_en = 1'b0;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sky    <= '0;
            r_force  <= '0;
            r_scroll <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SKY:    r_sky    <= i_cfg_data;
                CFG_FORCE:  r_force  <= i_cfg_data[SH_W-1:0];
                CFG_SCROLL: r_scroll <= i_cfg_data[SCR_W-1:0];
                default:    r_sky    <= r_sky;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_stp    <= '0;
            r_ch     <= '0;
            r_dact   <= 1'b0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_vx[i]  <= '0;
                r_vy[i]  <= '0;
                r_vd[i]  <= '0;
                r_col[i] <= '0;
                r_vu[i]  <= '0;
                r_vv[i]  <= '0;
            end
        end else begin
            r_state <= n_state;
            if (div_req.start) begin
                r_dact <= 1'b1;
            end else if (div_rsp.done) begin
                r_dact <= 1'b0;
            end
            if (r_state != n_state) begin
                r_stp <= '0;
                r_ch  <= '0;
            end else if (r_state == ST_ZI) begin
                if (div_rsp.done) r_stp <= r_stp + 1'b1;
            end else if (r_state == ST_SHADE && r_stp == 3'd2) begin
                r_stp <= '0;
                r_ch  <= r_ch + 1'b1;
            end else if (mac_en) begin
                r_stp <= r_stp + 1'b1;
            end
            if (r_state == ST_DONE && n_state == ST_IDLE) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
            if (accept && i_cmd.data.cmd == CMD_LOAD && i_cmd.data.vertex_slot != 2'd3) begin
                r_vx[i_cmd.data.vertex_slot]  <= i_cmd.data.pos_x;
                r_vy[i_cmd.data.vertex_slot]  <= i_cmd.data.pos_y;
                r_vd[i_cmd.data.vertex_slot]  <= i_cmd.data.depth_in;
                r_col[i_cmd.data.vertex_slot] <= i_cmd.data.color_in;
                r_vu[i_cmd.data.vertex_slot]  <= i_cmd.data.tex_u;
                r_vv[i_cmd.data.vertex_slot]  <= i_cmd.data.tex_v;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (mac_en) r_acc <= acc_next;
        case (r_state)
            ST_IDLE: begin
                r_clr   <= '0;
                r_rcol  <= '0;
                r_rdep  <= '0;
                r_cnt   <= '0;
                r_shader <= (r_force != '0) ? r_force : i_cmd.data.shader_sel;
                r_base  <= i_cmd.data.tex_base;
                r_size  <= (i_cmd.data.tex_size == '0) ? TSZ_W'(1) : i_cmd.data.tex_size;
                r_px    <= XW'(i_cmd.data.pos_x);
                r_py    <= YW'(i_cmd.data.pos_y);
                r_inscr <= (i_cmd.data.pos_x >= 0) && (i_cmd.data.pos_x < SCREEN_W)
                        && (i_cmd.data.pos_y >= 0) && (i_cmd.data.pos_y < SCREEN_H);
            end
            ST_CLEAR: r_clr <= r_clr + 1'b1;
            ST_RDCAP: begin
                if (r_inscr) begin
                    r_rcol <= fr_rdata;
                    r_rdep <= dp_rdata;
                end
            end
            ST_ZI:   if (div_rsp.done) r_zi[r_stp[1:0]] <= div_rsp.quo[ZI_W-1:0];
            ST_AREA: if (r_stp == 3'd1) r_area <= acc_next[E_W-1:0];
            ST_BOX: begin
                r_xs <= XW'(xs_c);
                r_xl <= XW'(xl_c);
                r_yl <= YW'(yl_c);
                r_ys <= YW'(ys_c);
                r_px <= XW'(xs_c);
                r_py <= YW'(ys_c);
            end
            ST_EDGE: if (r_stp[0]) r_e[r_stp[2:1]] <= acc_next[E_W-1:0];
            ST_W1:   if (div_rsp.done) r_w[0] <= div_rsp.quo[W_W-1:0];
            ST_W2: begin
                if (div_rsp.done) begin
                    r_w[1] <= div_rsp.quo[W_W-1:0];
                    r_w[2] <= W_W'(FIX_ONE) - r_w[0] - div_rsp.quo[W_W-1:0];
                end
            end
            ST_DEN:  if (r_stp == 3'd2) r_den <= acc_next[DEN_W-1:0];
            ST_Z:    if (div_rsp.done) r_z <= div_rsp.quo[Z_W-1:0];
            ST_TEST: begin
                r_fcol <= '0;
                if (pass && r_cnt != CNT_W'(CNT_MAX)) r_cnt <= r_cnt + 1'b1;
            end
            ST_SHADE: begin
                if (r_stp == 3'd2) begin
                    if (r_shader == SH_GOURAUD) begin
                        logic [NIB_W-1:0] nb;
                        nb = acc_next[FIX_SH +: NIB_W];
                        if (nb != NIB_W'(NIBBLE_MAX)) nb = nb + 1'b1;
                        case (r_ch)
                            2'd0:    r_fcol[3:0]   <= nb;
                            2'd1:    r_fcol[11:8]  <= nb;
                            default: r_fcol[15:12] <= nb;
                        endcase
                    end else if (r_ch == 2'd0) begin
                        r_iu <= acc_next[FIX_SH +: UV_W];
                    end else begin
                        r_iv <= acc_next[FIX_SH +: UV_W];
                    end
                end
            end
            ST_TADDR: r_taddr <= taddr_full[TEX_AW-1:0];
            ST_NEXT: begin
                if (last_x) begin
                    r_px <= r_xs;
                    r_py <= r_py + 1'b1;
                end else begin
                    r_px <= r_px + 1'b1;
                end
            end
            ST_DONE: begin
                if (n_state == ST_IDLE) begin
                    r_out.read_color   <= r_rcol;
                    r_out.read_depth   <= $signed(r_rdep);
                    r_out.pixels_drawn <= r_cnt;
                end
            end
            default: r_clr <= r_clr;
        endcase
    end

    assign tx_we    = accept && (i_cmd.data.cmd == CMD_TEXEL);
    assign tx_waddr = TEX_AW'(i_cmd.data.tex_base);

    trz_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    trz_ram #(.WIDTH(COL_W), .DEPTH(PIX_N)) u_frame (
        .i_clk   (i_clk),
        .i_we    (fr_we),
        .i_waddr (st_waddr),
        .i_wdata (fr_wdata),
        .i_raddr (pix_addr),
        .o_rdata (fr_rdata)
    );

    trz_ram #(.WIDTH(ZST_W), .DEPTH(PIX_N)) u_depth (
        .i_clk   (i_clk),
        .i_we    (dp_we),
        .i_waddr (st_waddr),
        .i_wdata (dp_wdata),
        .i_raddr (pix_addr),
        .o_rdata (dp_rdata)
    );

    trz_ram #(.WIDTH(COL_W), .DEPTH(TEXEL_WORDS)) u_texel (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (tx_waddr),
        .i_wdata (i_cmd.data.color_in),
        .i_raddr (r_taddr),
        .o_rdata (tx_rdata)
    );

    a_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EDGE) |-> (r_px < r_xl) && (r_py < r_yl))
        else $error("pixel walk left the clipped box");

    a_wsum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DEN) |->
            ((W_W+1)'(r_w[0]) + (W_W+1)'(r_w[1]) <= (W_W+1)'(FIX_ONE)))
        else $error("barycentric weights exceed one");

    a_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> r_dact)
        else $error("divider finished without a request");

    a_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> $past(r_state == ST_DONE))
        else $error("result word raised outside completion");

endmodule

`default_nettype wire
